FILE: rtl/rmq_pkg.sv
// ============================================================================
// rmq_pkg
// Shared types and fixed-point constants for the matrix-to-quaternion block.
// ============================================================================
`default_nettype none

package rmq_pkg;

    // Fraction bits of a column-normalized matrix entry.
    localparam int SCALE_F = 30;
    // Width of a normalized entry, signed, range -1.0 to +1.0.
    localparam int N_W     = 32;
    // Width of the trace and the branch argument candidates, signed.
    localparam int TR_W    = 34;
    // Width of a pair sum or difference of normalized entries, signed.
    localparam int PS_W    = 33;
    // Width of the clamped branch argument, unsigned.
    localparam int ARG_W   = 33;
    // Width of r = sqrt(arg) in Q30, unsigned.
    localparam int RQ_W    = 32;
    // Width of the magnitude of a quotient numerator.
    localparam int NUM_W   = 32;

    localparam logic signed [TR_W-1:0] ONE_Q30 = TR_W'(64'sd1 <<< SCALE_F);

    typedef logic [1:0] t_br;

    localparam t_br BR_TRACE = 2'd0;
    localparam t_br BR_X     = 2'd1;
    localparam t_br BR_Y     = 2'd2;
    localparam t_br BR_Z     = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion.sv
// ============================================================================
// rotation_matrix_to_quaternion
// Converts the upper-left 3x3 of a transform matrix (signed Q8.24) into a
// quaternion (signed Q2.30), normalizing each column to unit length first.
// ============================================================================
// Usage. An item is the nine matrix entries i_r0c0 .. i_r2c2. It is taken at
// a rising clock edge where start is high and busy is low. busy is always low:
// the pipeline takes a new item in every cycle, so the sustained rate is one
// item per clock.
// Each result (o_qx, o_qy, o_qz, o_qw, o_div_zero) is shown for exactly one
// cycle with o_strobe high, in the order the items were taken. On its way an
// item passes, in order, the bit-per-stage square root pipeline for the column
// lengths, the bit-per-stage divider pipeline for column normalization, the
// square root pipeline for the branch scale and the divider pipeline for the
// quaternion components.
// The receiver cannot stall: nothing holds results, and none are needed since
// every stage advances in every cycle.
// Reset is synchronous and active low. It clears all valid bits, so no strobe
// appears until a new item has crossed the whole pipeline; data registers keep
// whatever they held.
// When the chosen branch gives S = 0, o_div_zero is high and all four
// components are zero.
// ============================================================================
`default_nettype none

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int IN_WIDTH  = 32,
    parameter int OUT_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [IN_WIDTH-1:0]  i_r0c0,
    input  wire logic signed [IN_WIDTH-1:0]  i_r0c1,
    input  wire logic signed [IN_WIDTH-1:0]  i_r0c2,
    input  wire logic signed [IN_WIDTH-1:0]  i_r1c0,
    input  wire logic signed [IN_WIDTH-1:0]  i_r1c1,
    input  wire logic signed [IN_WIDTH-1:0]  i_r1c2,
    input  wire logic signed [IN_WIDTH-1:0]  i_r2c0,
    input  wire logic signed [IN_WIDTH-1:0]  i_r2c1,
    input  wire logic signed [IN_WIDTH-1:0]  i_r2c2,
    output logic                             o_strobe,
    output logic signed [OUT_WIDTH-1:0]      o_qx,
    output logic signed [OUT_WIDTH-1:0]      o_qy,
    output logic signed [OUT_WIDTH-1:0]      o_qz,
    output logic signed [OUT_WIDTH-1:0]      o_qw,
    output logic                             o_div_zero
);

    localparam int W    = IN_WIDTH;
    localparam int H    = (W + 1) / 2;     // low half of a magnitude
    localparam int AW   = W - H;           // high half of a magnitude
    localparam int SQW  = 2 * W;           // square and column length
    localparam int ES_W = W + 1;           // sign plus magnitude of an entry
    localparam int OF   = OUT_WIDTH - 2;   // output fraction bits
    localparam int QW   = OF + 1;          // quotient bits from the divider
    localparam int S2W  = 2 + 3 + 3 * NUM_W;
    localparam int S3W  = 2 + 3 + RQ_W;
    localparam int LAT  = 4 + W + (SCALE_F + 1) + 3 + RQ_W + (OF + 1) + 1;

    localparam logic signed [OUT_WIDTH-1:0] Q_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic signed [OUT_WIDTH-1:0] Q_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    logic [W-1:0] s_in [9];

    assign s_in[0] = i_r0c0;
    assign s_in[1] = i_r0c1;
    assign s_in[2] = i_r0c2;
    assign s_in[3] = i_r1c0;
    assign s_in[4] = i_r1c1;
    assign s_in[5] = i_r1c2;
    assign s_in[6] = i_r2c0;
    assign s_in[7] = i_r2c1;
    assign s_in[8] = i_r2c2;

    // The pipeline never blocks.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Front end: sign/magnitude split, squares as three half-width
    // partial products, then the three column lengths squared.
    // ------------------------------------------------------------------
    logic [3:0]        r_fvld;
    logic              r1_neg [9];
    logic [W-1:0]      r1_mag [9];
    logic              r2_neg [9];
    logic [W-1:0]      r2_mag [9];
    logic [2*AW-1:0]   r2_hh  [9];
    logic [AW+H-1:0]   r2_hl  [9];
    logic [2*H-1:0]    r2_ll  [9];
    logic              r3_neg [9];
    logic [W-1:0]      r3_mag [9];
    logic [SQW-1:0]    r3_sq  [9];
    logic [SQW-1:0]    r4_len [3];
    logic [9*ES_W-1:0] r4_side;

    logic              n1_neg [9];
    logic [W-1:0]      n1_mag [9];
    logic [2*AW-1:0]   n2_hh  [9];
    logic [AW+H-1:0]   n2_hl  [9];
    logic [2*H-1:0]    n2_ll  [9];
    logic [SQW-1:0]    n3_sq  [9];
    logic [SQW-1:0]    n4_len [3];
    logic [9*ES_W-1:0] n4_side;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n1_neg[i] = s_in[i][W-1];
            n1_mag[i] = s_in[i][W-1] ? W'(-s_in[i]) : s_in[i];
            n2_hh[i]  = (2*AW)'(r1_mag[i][W-1:H]) * (2*AW)'(r1_mag[i][W-1:H]);
            n2_hl[i]  = (AW+H)'(r1_mag[i][W-1:H]) * (AW+H)'(r1_mag[i][H-1:0]);
            n2_ll[i]  = (2*H)'(r1_mag[i][H-1:0]) * (2*H)'(r1_mag[i][H-1:0]);
            n3_sq[i]  = (SQW'(r2_hh[i]) << (2*H)) + (SQW'(r2_hl[i]) << (H+1))
                      + SQW'(r2_ll[i]);
            n4_side[i*ES_W +: ES_W] = {r3_neg[i], r3_mag[i]};
        end
        for (int c = 0; c < 3; c++) begin
            n4_len[c] = r3_sq[c] + r3_sq[3+c] + r3_sq[6+c];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_neg  <= n1_neg;
        r1_mag  <= n1_mag;
        r2_neg  <= r1_neg;
        r2_mag  <= r1_mag;
        r2_hh   <= n2_hh;
        r2_hl   <= n2_hl;
        r2_ll   <= n2_ll;
        r3_neg  <= r2_neg;
        r3_mag  <= r2_mag;
        r3_sq   <= n3_sq;
        r4_len  <= n4_len;
        r4_side <= n4_side;
    end

    // ------------------------------------------------------------------
    // Column lengths: d = floor(sqrt(L)), one lane per column.
    // ------------------------------------------------------------------
    logic              sq1_vld;
    logic [W-1:0]      sq1_d    [3];
    logic [9*ES_W-1:0] sq1_side;

    rmq_isqrt_pipe #(
        .LANES (3),
        .RW    (W),
        .SW    (9*ES_W)
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_fvld[3]),
        .i_rad   (r4_len),
        .i_side  (r4_side),
        .o_vld   (sq1_vld),
        .o_root  (sq1_d),
        .o_side  (sq1_side)
    );

    // ------------------------------------------------------------------
    // Column normalization: |e| * 2^30 / d for all nine entries. Since
    // |e| <= d, the overflow flag is raised only for a zero-length column,
    // and it then forces the entry to zero.
    // ------------------------------------------------------------------
    logic [W-1:0] dv1_num [9];
    logic [W-1:0] dv1_den [9];
    logic [8:0]   dv1_neg_in;
    logic         dv1_vld;
    logic [SCALE_F:0] dv1_q [9];
    logic         dv1_sat [9];
    logic [8:0]   dv1_neg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            dv1_num[i]    = sq1_side[i*ES_W +: W];
            dv1_neg_in[i] = sq1_side[i*ES_W + W];
            dv1_den[i]    = sq1_d[i % 3];
        end
    end

    rmq_div_pipe #(
        .LANES (9),
        .NW    (W),
        .DW    (W),
        .F     (SCALE_F),
        .SW    (9)
    ) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sq1_vld),
        .i_num   (dv1_num),
        .i_den   (dv1_den),
        .i_side  (dv1_neg_in),
        .o_vld   (dv1_vld),
        .o_q     (dv1_q),
        .o_sat   (dv1_sat),
        .o_side  (dv1_neg)
    );

    // ------------------------------------------------------------------
    // Branch selection over three stages: signed entries, then trace,
    // comparisons and sums, then the branch, its clamped argument and the
    // three numerators as sign and magnitude.
    // ------------------------------------------------------------------
    logic [2:0]              r_tvld;
    logic signed [N_W-1:0]   r_n [9];
    logic signed [TR_W-1:0]  r_tr;
    logic                    r_g01;
    logic                    r_g02;
    logic                    r_g12;
    logic signed [TR_W-1:0]  r_arg [4];
    logic signed [PS_W-1:0]  r_p01;
    logic signed [PS_W-1:0]  r_p02;
    logic signed [PS_W-1:0]  r_p12;
    logic signed [PS_W-1:0]  r_m21;
    logic signed [PS_W-1:0]  r_m02;
    logic signed [PS_W-1:0]  r_m10;
    logic [2*RQ_W-1:0]       r_rad [1];
    logic [S2W-1:0]          r_side2;

    logic signed [N_W-1:0]   n_n [9];
    logic signed [TR_W-1:0]  n_arg [4];
    logic [2*RQ_W-1:0]       n_rad [1];
    logic [S2W-1:0]          n_side2;

    always_comb begin
        t_br                    br;
        logic signed [TR_W-1:0] a_sel;
        logic [ARG_W-1:0]       arg;
        logic signed [PS_W-1:0] num [3];
        logic                   sg  [3];
        logic [NUM_W-1:0]       mg  [3];
        for (int i = 0; i < 9; i++) begin
            if (dv1_sat[i]) begin
                n_n[i] = '0;
            end else if (dv1_neg[i]) begin
                n_n[i] = -N_W'(dv1_q[i]);
            end else begin
                n_n[i] = N_W'(dv1_q[i]);
            end
        end
        n_arg[0] = TR_W'(r_n[0]) + TR_W'(r_n[4]) + TR_W'(r_n[8]) + ONE_Q30;
        n_arg[1] = ONE_Q30 + TR_W'(r_n[0]) - TR_W'(r_n[4]) - TR_W'(r_n[8]);
        n_arg[2] = ONE_Q30 + TR_W'(r_n[4]) - TR_W'(r_n[0]) - TR_W'(r_n[8]);
        n_arg[3] = ONE_Q30 + TR_W'(r_n[8]) - TR_W'(r_n[0]) - TR_W'(r_n[4]);

        // Strict comparisons; ties fall through to the later branch.
        if (r_tr > 0) begin
            br = BR_TRACE;
        end else if (r_g01 && r_g02) begin
            br = BR_X;
        end else if (r_g12) begin
            br = BR_Y;
        end else begin
            br = BR_Z;
        end

        case (br)
            BR_TRACE: begin
                a_sel = r_arg[0];
                num[0] = r_m21; num[1] = r_m02; num[2] = r_m10;
            end
            BR_X: begin
                a_sel = r_arg[1];
                num[0] = r_p01; num[1] = r_p02; num[2] = r_m21;
            end
            BR_Y: begin
                a_sel = r_arg[2];
                num[0] = r_p01; num[1] = r_p12; num[2] = r_m02;
            end
            default: begin
                a_sel = r_arg[3];
                num[0] = r_p02; num[1] = r_p12; num[2] = r_m10;
            end
        endcase

        arg = a_sel[TR_W-1] ? '0 : ARG_W'(a_sel);
        // arg * 2^30 as the square root radicand, so r is sqrt(arg) in Q30.
        n_rad[0] = (2*RQ_W)'({arg, {SCALE_F{1'b0}}});

        for (int j = 0; j < 3; j++) begin
            sg[j] = num[j][PS_W-1];
            mg[j] = NUM_W'(sg[j] ? -num[j] : num[j]);
        end
        n_side2 = {br, sg[0], sg[1], sg[2], mg[0], mg[1], mg[2]};
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_tr    <= TR_W'(r_n[0]) + TR_W'(r_n[4]) + TR_W'(r_n[8]);
        r_g01   <= r_n[0] > r_n[4];
        r_g02   <= r_n[0] > r_n[8];
        r_g12   <= r_n[4] > r_n[8];
        r_arg   <= n_arg;
        r_p01   <= PS_W'(r_n[1]) + PS_W'(r_n[3]);
        r_p02   <= PS_W'(r_n[2]) + PS_W'(r_n[6]);
        r_p12   <= PS_W'(r_n[5]) + PS_W'(r_n[7]);
        r_m21   <= PS_W'(r_n[7]) - PS_W'(r_n[5]);
        r_m02   <= PS_W'(r_n[2]) - PS_W'(r_n[6]);
        r_m10   <= PS_W'(r_n[3]) - PS_W'(r_n[1]);
        r_rad   <= n_rad;
        r_side2 <= n_side2;
    end

    // ------------------------------------------------------------------
    // Branch scale r = sqrt(arg) in Q30; S = 2r.
    // ------------------------------------------------------------------
    logic              sq2_vld;
    logic [RQ_W-1:0]   sq2_r [1];
    logic [S2W-1:0]    sq2_side;

    rmq_isqrt_pipe #(
        .LANES (1),
        .RW    (RQ_W),
        .SW    (S2W)
    ) u_scale_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_tvld[2]),
        .i_rad   (r_rad),
        .i_side  (r_side2),
        .o_vld   (sq2_vld),
        .o_root  (sq2_r),
        .o_side  (sq2_side)
    );

    // ------------------------------------------------------------------
    // Component division: |num| * 2^OF / (2r), three lanes. The overflow
    // flag (quotient of two or more) means saturation.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  dv2_num [3];
    logic [RQ_W:0]     dv2_den [3];
    logic [S3W-1:0]    dv2_side_in;
    logic              dv2_vld;
    logic [QW-1:0]     dv2_q   [3];
    logic              dv2_sat [3];
    logic [S3W-1:0]    dv2_side;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            dv2_num[j] = sq2_side[(2-j)*NUM_W +: NUM_W];
            dv2_den[j] = {sq2_r[0], 1'b0};
        end
        dv2_side_in = {sq2_side[S2W-1 -: 5], sq2_r[0]};
    end

    rmq_div_pipe #(
        .LANES (3),
        .NW    (NUM_W),
        .DW    (RQ_W + 1),
        .F     (OF),
        .SW    (S3W)
    ) u_comp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sq2_vld),
        .i_num   (dv2_num),
        .i_den   (dv2_den),
        .i_side  (dv2_side_in),
        .o_vld   (dv2_vld),
        .o_q     (dv2_q),
        .o_sat   (dv2_sat),
        .o_side  (dv2_side)
    );

    // ------------------------------------------------------------------
    // Output stage: signs and saturation, S/4, placement by branch.
    // ------------------------------------------------------------------
    logic                        r_strobe;
    logic                        r_dz;
    logic signed [OUT_WIDTH-1:0] r_qx;
    logic signed [OUT_WIDTH-1:0] r_qy;
    logic signed [OUT_WIDTH-1:0] r_qz;
    logic signed [OUT_WIDTH-1:0] r_qw;

    logic                        n_dz;
    logic signed [OUT_WIDTH-1:0] n_qx;
    logic signed [OUT_WIDTH-1:0] n_qy;
    logic signed [OUT_WIDTH-1:0] n_qz;
    logic signed [OUT_WIDTH-1:0] n_qw;

    always_comb begin
        t_br                         obr;
        logic [RQ_W-1:0]             rr;
        logic                        sg [3];
        logic signed [OUT_WIDTH-1:0] lv [3];
        logic [RQ_W+OF-1:0]          qfull;
        logic signed [OUT_WIDTH-1:0] qs;
        obr   = dv2_side[S3W-1 -: 2];
        rr    = dv2_side[RQ_W-1:0];
        sg[0] = dv2_side[RQ_W+2];
        sg[1] = dv2_side[RQ_W+1];
        sg[2] = dv2_side[RQ_W];
        for (int j = 0; j < 3; j++) begin
            if (dv2_sat[j]) begin
                lv[j] = sg[j] ? Q_MIN : Q_MAX;
            end else if (sg[j]) begin
                lv[j] = -OUT_WIDTH'(dv2_q[j]);
            end else begin
                lv[j] = OUT_WIDTH'(dv2_q[j]);
            end
        end
        // S/4 = r / 2 in Q30, rescaled to the output fraction.
        qfull = {rr, {OF{1'b0}}};
        qs    = OUT_WIDTH'(qfull[RQ_W+OF-1:31]);
        case (obr)
            BR_TRACE: begin
                n_qx = lv[0]; n_qy = lv[1]; n_qz = lv[2]; n_qw = qs;
            end
            BR_X: begin
                n_qx = qs; n_qy = lv[0]; n_qz = lv[1]; n_qw = lv[2];
            end
            BR_Y: begin
                n_qx = lv[0]; n_qy = qs; n_qz = lv[1]; n_qw = lv[2];
            end
            default: begin
                n_qx = lv[0]; n_qy = lv[1]; n_qz = qs; n_qw = lv[2];
            end
        endcase
        n_dz = (rr == '0);
        if (n_dz) begin
            n_qx = '0;
            n_qy = '0;
            n_qz = '0;
            n_qw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld   <= '0;
            r_tvld   <= '0;
            r_strobe <= 1'b0;
            r_dz     <= 1'b0;
        end else begin
            r_fvld   <= {r_fvld[2:0], start & ~busy};
            r_tvld   <= {r_tvld[1:0], dv1_vld};
            r_strobe <= dv2_vld;
            r_dz     <= dv2_vld & n_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx <= n_qx;
        r_qy <= n_qy;
        r_qz <= n_qz;
        r_qw <= n_qw;
    end

    assign o_strobe   = r_strobe;
    assign o_div_zero = r_dz;
    assign o_qx       = r_qx;
    assign o_qy       = r_qy;
    assign o_qz       = r_qz;
    assign o_qw       = r_qw;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_dz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_div_zero |-> o_qx == 0 && o_qy == 0 && o_qz == 0 && o_qw == 0)
        else $error("div_zero result with nonzero components");

    a_strobe_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result strobe without an item taken at the pipeline latency");

    a_dz_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_div_zero)
        else $error("div_zero raised outside a result cycle");

endmodule

`default_nettype wire

FILE: rtl/rmq_isqrt_pipe.sv
// ============================================================================
// rmq_isqrt_pipe
// Pipelined integer square root, one root bit per stage, several lanes that
// share one valid bit and one sideband word.
// ============================================================================
`default_nettype none

module rmq_isqrt_pipe #(
    parameter int LANES = 1,
    parameter int RW    = 32,
    parameter int SW    = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic [2*RW-1:0]   i_rad [LANES],
    input  wire logic [SW-1:0]     i_side,
    output logic                   o_vld,
    output logic [RW-1:0]          o_root [LANES],
    output logic [SW-1:0]          o_side
);

    logic [RW-1:0]   r_root [RW][LANES];
    logic [RW+1:0]   r_rem  [RW][LANES];
    logic [2*RW-1:0] r_rad  [RW][LANES];
    logic [SW-1:0]   r_side [RW];
    logic [RW-1:0]   r_vld;

    logic [RW-1:0]   n_root [RW][LANES];
    logic [RW+1:0]   n_rem  [RW][LANES];
    logic [2*RW-1:0] n_rad  [RW][LANES];
    logic [SW-1:0]   n_side [RW];
    logic [RW-1:0]   n_vld;

    // Each stage brings down two radicand bits and decides one root bit.
    always_comb begin
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic          ge;
        n_vld = {r_vld[RW-2:0], i_vld};
        n_side[0] = i_side;
        for (int k = 1; k < RW; k++) begin
            n_side[k] = r_side[k-1];
        end
        for (int l = 0; l < LANES; l++) begin
            cur   = (RW+4)'(i_rad[l][2*RW-1 -: 2]);
            trial = (RW+4)'(1);
            ge    = cur >= trial;
            n_rem[0][l]  = (RW+2)'(ge ? cur - trial : cur);
            n_root[0][l] = RW'(ge);
            n_rad[0][l]  = i_rad[l] << 2;
            for (int k = 1; k < RW; k++) begin
                cur   = {r_rem[k-1][l], r_rad[k-1][l][2*RW-1 -: 2]};
                trial = (RW+4)'({r_root[k-1][l], 2'b01});
                ge    = cur >= trial;
                n_rem[k][l]  = (RW+2)'(ge ? cur - trial : cur);
                n_root[k][l] = {r_root[k-1][l][RW-2:0], ge};
                n_rad[k][l]  = r_rad[k-1][l] << 2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root <= n_root;
        r_rem  <= n_rem;
        r_rad  <= n_rad;
        r_side <= n_side;
    end

    assign o_vld  = r_vld[RW-1];
    assign o_side = r_side[RW-1];
    assign o_root = r_root[RW-1];

endmodule

`default_nettype wire

FILE: rtl/rmq_div_pipe.sv
// ============================================================================
// rmq_div_pipe
// Pipelined fractional divider: floor(num * 2^F / den) with a one-bit integer
// part, one quotient bit per stage, and a flag for num >= 2 * den.
// ============================================================================
`default_nettype none

module rmq_div_pipe #(
    parameter int LANES = 1,
    parameter int NW    = 32,
    parameter int DW    = 32,
    parameter int F     = 30,
    parameter int SW    = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    input  wire logic [NW-1:0]   i_num [LANES],
    input  wire logic [DW-1:0]   i_den [LANES],
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_vld,
    output logic [F:0]           o_q   [LANES],
    output logic                 o_sat [LANES],
    output logic [SW-1:0]        o_side
);

    localparam int CW = NW + DW + 2;

    logic [DW-1:0] r_rem  [F+1][LANES];
    logic [DW-1:0] r_den  [F+1][LANES];
    logic [F:0]    r_q    [F+1][LANES];
    logic          r_sat  [F+1][LANES];
    logic [SW-1:0] r_side [F+1];
    logic [F:0]    r_vld;

    logic [DW-1:0] n_rem  [F+1][LANES];
    logic [DW-1:0] n_den  [F+1][LANES];
    logic [F:0]    n_q    [F+1][LANES];
    logic          n_sat  [F+1][LANES];
    logic [SW-1:0] n_side [F+1];
    logic [F:0]    n_vld;

    always_comb begin
        logic [CW-1:0] num_x;
        logic [CW-1:0] den_x;
        logic [DW:0]   two;
        logic          ge;
        n_vld = {r_vld[F-1:0], i_vld};
        n_side[0] = i_side;
        for (int k = 1; k <= F; k++) begin
            n_side[k] = r_side[k-1];
        end
        for (int l = 0; l < LANES; l++) begin
            // First stage settles the integer bit and the overflow flag.
            num_x = CW'(i_num[l]);
            den_x = CW'(i_den[l]);
            ge    = num_x >= den_x;
            n_sat[0][l] = num_x >= (den_x << 1);
            n_rem[0][l] = DW'(ge ? num_x - den_x : num_x);
            n_den[0][l] = i_den[l];
            n_q[0][l]   = (F+1)'(ge);
            for (int k = 1; k <= F; k++) begin
                two = {r_rem[k-1][l], 1'b0};
                ge  = two >= {1'b0, r_den[k-1][l]};
                n_rem[k][l] = DW'(ge ? two - {1'b0, r_den[k-1][l]} : two);
                n_den[k][l] = r_den[k-1][l];
                n_q[k][l]   = {r_q[k-1][l][F-1:0], ge};
                n_sat[k][l] = r_sat[k-1][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
        r_sat  <= n_sat;
        r_side <= n_side;
    end

    assign o_vld  = r_vld[F];
    assign o_side = r_side[F];
    assign o_q    = r_q[F];
    assign o_sat  = r_sat[F];

endmodule

`default_nettype wire
